// ----- design/tla_pkg.sv -----
package tla_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_source;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_NUMBER_MODE      = 3'd0;
	localparam logic [2:0] REG_SHOW_ENDS        = 3'd1;
	localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
	localparam logic [2:0] REG_SHOW_TABS        = 3'd3;
	localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd4;

	localparam logic [1:0] MODE_ALL = 2'd1;
	localparam logic [1:0] MODE_OFF = 2'd0;

	// Numbers are right-aligned in this many columns.
	localparam int NUM_FIELD_WIDTH = 6;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [6:0] CH_DEL7   = 7'h7F;

	localparam int PC_W     = 5;
	localparam int PROG_LEN = 27;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_NEVER,
		C_NOT_NL,
		C_SQUEEZE,
		C_NOT_NUM_BLANK,
		C_IDX_NZ,
		C_NOT_ENDS,
		C_CHAR_NUM,
		C_NOT_TAB,
		C_NOT_SHOW_TABS,
		C_NOT_SHOW_NP,
		C_NOT_HIGH,
		C_NOT_CTRL,
		C_NOT_DEL
	} cond_t;

	typedef enum logic [3:0] {
		E_NONE,
		E_NUM,
		E_TAB,
		E_DOLLAR,
		E_NL,
		E_CARET,
		E_LET_I,
		E_LET_M,
		E_DASH,
		E_CTRL,
		E_QMARK,
		E_LOW7,
		E_RAW
	} emit_t;

	typedef enum logic [2:0] {
		O_NONE,
		O_SET_PREV,
		O_CLR_PREV,
		O_SET_ALS,
		O_CLR_ALS,
		O_LOAD_IDX,
		O_DEC_IDX,
		O_INC_COUNT
	} op_t;

	typedef struct packed {
		cond_t           cond;
		logic [PC_W-1:0] target;
		emit_t           emit;
		op_t             op;
		logic            done;
	} ucode_t;

	// Program addresses.
	localparam logic [PC_W-1:0] A_DISPATCH  = 5'd0;
	localparam logic [PC_W-1:0] A_NL        = 5'd1;
	localparam logic [PC_W-1:0] A_NL_PREV   = 5'd2;
	localparam logic [PC_W-1:0] A_NUM_INIT  = 5'd3;
	localparam logic [PC_W-1:0] A_NUM_LOOP  = 5'd4;
	localparam logic [PC_W-1:0] A_NUM_TAB   = 5'd5;
	localparam logic [PC_W-1:0] A_NL_TAIL   = 5'd6;
	localparam logic [PC_W-1:0] A_DOLLAR    = 5'd7;
	localparam logic [PC_W-1:0] A_NL_EMIT   = 5'd8;
	localparam logic [PC_W-1:0] A_DROP      = 5'd9;
	localparam logic [PC_W-1:0] A_CHAR      = 5'd10;
	localparam logic [PC_W-1:0] A_BODY      = 5'd11;
	localparam logic [PC_W-1:0] A_TAB_SHOW  = 5'd12;
	localparam logic [PC_W-1:0] A_TAB_CARET = 5'd13;
	localparam logic [PC_W-1:0] A_TAB_I     = 5'd14;
	localparam logic [PC_W-1:0] A_NP        = 5'd15;
	localparam logic [PC_W-1:0] A_NP_HIGH   = 5'd16;
	localparam logic [PC_W-1:0] A_NP_M      = 5'd17;
	localparam logic [PC_W-1:0] A_NP_DASH   = 5'd18;
	localparam logic [PC_W-1:0] A_NP_LOW    = 5'd19;
	localparam logic [PC_W-1:0] A_CTL_CARET = 5'd20;
	localparam logic [PC_W-1:0] A_CTL_CHAR  = 5'd21;
	localparam logic [PC_W-1:0] A_NP_DEL    = 5'd22;
	localparam logic [PC_W-1:0] A_DEL_CARET = 5'd23;
	localparam logic [PC_W-1:0] A_DEL_QMARK = 5'd24;
	localparam logic [PC_W-1:0] A_LOW7      = 5'd25;
	localparam logic [PC_W-1:0] A_RAW       = 5'd26;

	function automatic ucode_t uw(input cond_t c, input logic [PC_W-1:0] t,
			input emit_t e, input op_t o, input logic d);
		ucode_t w;
		w.cond   = c;
		w.target = t;
		w.emit   = e;
		w.op     = o;
		w.done   = d;
		return w;
	endfunction

	// The control store: one word per step.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			A_DISPATCH:  w = uw(C_NOT_NL,        A_CHAR,     E_NONE,   O_NONE,      1'b0);
			A_NL:        w = uw(C_SQUEEZE,       A_DROP,     E_NONE,   O_NONE,      1'b0);
			A_NL_PREV:   w = uw(C_NOT_NUM_BLANK, A_NL_TAIL,  E_NONE,   O_SET_PREV,  1'b0);
			A_NUM_INIT:  w = uw(C_NEVER,         A_DISPATCH, E_NONE,   O_LOAD_IDX,  1'b0);
			A_NUM_LOOP:  w = uw(C_IDX_NZ,        A_NUM_LOOP, E_NUM,    O_DEC_IDX,   1'b0);
			A_NUM_TAB:   w = uw(C_NOT_NL,        A_BODY,     E_TAB,    O_INC_COUNT, 1'b0);
			A_NL_TAIL:   w = uw(C_NOT_ENDS,      A_NL_EMIT,  E_NONE,   O_NONE,      1'b0);
			A_DOLLAR:    w = uw(C_NEVER,         A_DISPATCH, E_DOLLAR, O_NONE,      1'b0);
			A_NL_EMIT:   w = uw(C_NEVER,         A_DISPATCH, E_NL,     O_SET_ALS,   1'b1);
			A_DROP:      w = uw(C_NEVER,         A_DISPATCH, E_NONE,   O_SET_ALS,   1'b1);
			A_CHAR:      w = uw(C_CHAR_NUM,      A_NUM_INIT, E_NONE,   O_CLR_PREV,  1'b0);
			A_BODY:      w = uw(C_NOT_TAB,       A_NP,       E_NONE,   O_CLR_ALS,   1'b0);
			A_TAB_SHOW:  w = uw(C_NOT_SHOW_TABS, A_RAW,      E_NONE,   O_NONE,      1'b0);
			A_TAB_CARET: w = uw(C_NEVER,         A_DISPATCH, E_CARET,  O_NONE,      1'b0);
			A_TAB_I:     w = uw(C_NEVER,         A_DISPATCH, E_LET_I,  O_NONE,      1'b1);
			A_NP:        w = uw(C_NOT_SHOW_NP,   A_RAW,      E_NONE,   O_NONE,      1'b0);
			A_NP_HIGH:   w = uw(C_NOT_HIGH,      A_NP_LOW,   E_NONE,   O_NONE,      1'b0);
			A_NP_M:      w = uw(C_NEVER,         A_DISPATCH, E_LET_M,  O_NONE,      1'b0);
			A_NP_DASH:   w = uw(C_NEVER,         A_DISPATCH, E_DASH,   O_NONE,      1'b0);
			A_NP_LOW:    w = uw(C_NOT_CTRL,      A_NP_DEL,   E_NONE,   O_NONE,      1'b0);
			A_CTL_CARET: w = uw(C_NEVER,         A_DISPATCH, E_CARET,  O_NONE,      1'b0);
			A_CTL_CHAR:  w = uw(C_NEVER,         A_DISPATCH, E_CTRL,   O_NONE,      1'b1);
			A_NP_DEL:    w = uw(C_NOT_DEL,       A_LOW7,     E_NONE,   O_NONE,      1'b0);
			A_DEL_CARET: w = uw(C_NEVER,         A_DISPATCH, E_CARET,  O_NONE,      1'b0);
			A_DEL_QMARK: w = uw(C_NEVER,         A_DISPATCH, E_QMARK,  O_NONE,      1'b1);
			A_LOW7:      w = uw(C_NEVER,         A_DISPATCH, E_LOW7,   O_NONE,      1'b1);
			A_RAW:       w = uw(C_NEVER,         A_DISPATCH, E_RAW,    O_NONE,      1'b1);
			default:     w = uw(C_NEVER,         A_DISPATCH, E_NONE,   O_NONE,      1'b1);
		endcase
		return w;
	endfunction

endpackage

// ----- design/text_line_annotator.sv -----
// Text line annotator: takes a stream of text bytes and produces the annotated byte stream,
// with optional line numbers, squeezed blank lines, end-of-line marks, visible tabs and
// caret / M- notation for nonprinting bytes.
// Input channel: in_valid / in_stall carry one item (data_byte, new_source). An item is taken
// on a clock edge with in_valid high and in_stall low; new_source puts the block back at a
// line start before that byte.
// Output channel: out_valid / out_stall carry one result item per edge (out_byte, run_last);
// run_last marks the final byte that an input item caused. A squeezed newline gives nothing.
// Configuration: cfg_we, cfg_index and cfg_data write one register per edge. The user must
// write only while idle; the block itself does not enforce it. One item is worked on at a
// time by a microcoded sequencer that steps through a 27-word control store, one step per
// cycle unless an emitting step waits on a stalled output, and the next item can be taken
// in the cycle after the last step. The output register decouples the sides: the next item
// is accepted while the last result still waits. When the receiver stalls, the sequencer
// holds on its current emitting step.
// Reset clears the configuration to zero, the line counter to one and sets the line-start
// flag.
module text_line_annotator #(
	parameter int COUNT_DIGITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tla_pkg::in_item_t     in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tla_pkg::out_item_t    out_item,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [1:0]            cfg_data
);
	import tla_pkg::*;

	localparam int IDX_W = $clog2(COUNT_DIGITS);
	localparam logic [IDX_W-1:0] PAD_IDX = IDX_W'(NUM_FIELD_WIDTH - 1);

	// Configuration registers.
	logic [1:0] number_mode_q;
	logic       show_ends_q;
	logic       squeeze_blank_q;
	logic       show_tabs_q;
	logic       show_np_q;

	// Line state and the decimal counter, digit 0 least significant.
	logic       als_q;
	logic       prev_blank_q;
	logic [3:0] cnt_q [COUNT_DIGITS];
	logic [3:0] cnt_inc [COUNT_DIGITS];

	// Sequencer.
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [7:0]      byte_q;
	logic [IDX_W-1:0] idx_q;
	ucode_t          uw_cur;
	logic            cond_true;
	logic            step_go;
	logic            slot_free;
	logic            in_accept;
	logic [IDX_W-1:0] top_idx;
	logic [7:0]      emit_byte;
	logic            is_nl, is_tab;

	logic            out_valid_q;
	out_item_t       out_q;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign uw_cur    = ucode_rom(pc_q);
	assign slot_free = !out_valid_q || !out_stall;
	assign step_go   = busy_q && ((uw_cur.emit == E_NONE) || slot_free);

	assign is_nl  = (byte_q == CH_NL);
	assign is_tab = (byte_q == CH_TAB);

	// Highest nonzero digit; the units digit is always printed.
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < COUNT_DIGITS; i++) begin
			if (cnt_q[i] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	// Counter plus one, carrying through digits at nine.
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			cnt_inc[i] = cnt_q[i];
			if (carry) begin
				if (cnt_q[i] == 4'd9) begin
					cnt_inc[i] = 4'd0;
				end else begin
					cnt_inc[i] = cnt_q[i] + 4'd1;
					carry = 1'b0;
				end
			end
		end
	end

	always_comb begin
		case (uw_cur.cond)
			C_ALWAYS:        cond_true = 1'b1;
			C_NEVER:         cond_true = 1'b0;
			C_NOT_NL:        cond_true = !is_nl;
			C_SQUEEZE:       cond_true = squeeze_blank_q && als_q && prev_blank_q;
			C_NOT_NUM_BLANK: cond_true = !(als_q && (number_mode_q == MODE_ALL));
			C_IDX_NZ:        cond_true = (idx_q != '0);
			C_NOT_ENDS:      cond_true = !show_ends_q;
			C_CHAR_NUM:      cond_true = als_q && (number_mode_q != MODE_OFF);
			C_NOT_TAB:       cond_true = !is_tab;
			C_NOT_SHOW_TABS: cond_true = !show_tabs_q;
			C_NOT_SHOW_NP:   cond_true = !show_np_q;
			C_NOT_HIGH:      cond_true = !byte_q[7];
			C_NOT_CTRL:      cond_true = (byte_q[6:5] != 2'b00);
			C_NOT_DEL:       cond_true = (byte_q[6:0] != CH_DEL7);
			default:         cond_true = 1'b0;
		endcase
	end

	// A number column is a pad space until the top digit is reached.
	always_comb begin
		case (uw_cur.emit)
			E_NUM:    emit_byte = (idx_q > top_idx) ? CH_SPACE
			                    : (CH_ZERO | {4'd0, cnt_q[idx_q]});
			E_TAB:    emit_byte = CH_TAB;
			E_DOLLAR: emit_byte = CH_DOLLAR;
			E_NL:     emit_byte = CH_NL;
			E_CARET:  emit_byte = CH_CARET;
			E_LET_I:  emit_byte = CH_I;
			E_LET_M:  emit_byte = CH_M;
			E_DASH:   emit_byte = CH_DASH;
			E_CTRL:   emit_byte = {3'b010, byte_q[4:0]};
			E_QMARK:  emit_byte = CH_QMARK;
			E_LOW7:   emit_byte = {1'b0, byte_q[6:0]};
			E_RAW:    emit_byte = byte_q;
			default:  emit_byte = byte_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q   <= MODE_OFF;
			show_ends_q     <= 1'b0;
			squeeze_blank_q <= 1'b0;
			show_tabs_q     <= 1'b0;
			show_np_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUMBER_MODE:      number_mode_q   <= cfg_data;
				REG_SHOW_ENDS:        show_ends_q     <= cfg_data[0];
				REG_SQUEEZE_BLANK:    squeeze_blank_q <= cfg_data[0];
				REG_SHOW_TABS:        show_tabs_q     <= cfg_data[0];
				REG_SHOW_NONPRINTING: show_np_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, line state and counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pc_q         <= A_DISPATCH;
			als_q        <= 1'b1;
			prev_blank_q <= 1'b0;
			idx_q        <= '0;
			for (int i = 0; i < COUNT_DIGITS; i++) begin
				cnt_q[i] <= (i == 0) ? 4'd1 : 4'd0;
			end
		end else if (in_accept) begin
			busy_q <= 1'b1;
			pc_q   <= A_DISPATCH;
			if (in_item.new_source) begin
				als_q <= 1'b1;
			end
		end else if (step_go) begin
			if (uw_cur.done) begin
				busy_q <= 1'b0;
			end
			pc_q <= cond_true ? uw_cur.target : pc_q + PC_W'(1);
			case (uw_cur.op)
				O_SET_PREV:  prev_blank_q <= als_q;
				O_CLR_PREV:  prev_blank_q <= 1'b0;
				O_SET_ALS:   als_q <= 1'b1;
				O_CLR_ALS:   als_q <= 1'b0;
				O_LOAD_IDX:  idx_q <= (top_idx > PAD_IDX) ? top_idx : PAD_IDX;
				O_DEC_IDX:   idx_q <= idx_q - IDX_W'(1);
				O_INC_COUNT: cnt_q <= cnt_inc;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_q <= in_item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go && (uw_cur.emit != E_NONE)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && (uw_cur.emit != E_NONE)) begin
			out_q.out_byte <= emit_byte;
			out_q.run_last <= uw_cur.done;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> busy_q && (pc_q == A_DISPATCH))
		else $error("accepted item did not start the program");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < PC_W'(PROG_LEN)))
		else $error("step counter left the control store");

	// The index only has to address a digit while the number is being printed.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (pc_q == A_NUM_LOOP)) |-> (int'(idx_q) < COUNT_DIGITS))
		else $error("digit index beyond the counter");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !step_go || (uw_cur.emit == E_NONE))
		else $error("emitting step ran over a waiting result");

	a_units_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= 4'd9)
		else $error("counter digit out of decimal range");

endmodule

// ----- tb/tla_annotation_check.sv -----
`timescale 1ns / 100ps
module tla_annotation_check #(
	parameter int COUNT_DIGITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  tla_pkg::in_item_t   in_item,
	input  logic                out_valid,
	input  logic                out_stall,
	input  tla_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [1:0]          cfg_data,
	output int                  fail_count,
	output int                  open_count
);
	import tla_pkg::*;

	localparam logic [7:0] CTRL_OFFSET = 8'd64;

	logic [1:0] number_mode;
	logic       show_ends;
	logic       squeeze_blank;
	logic       show_tabs;
	logic       show_nonprinting;

	// Line counter in BCD, least significant digit first.
	logic [3:0] line_count [COUNT_DIGITS];
	logic       line_begin;
	logic       prev_blank;

	logic [7:0] run_bytes [$];
	out_item_t  awaited_bytes [$];
	int         failures;

	task automatic emit_line_number();
		int  top_digit;
		logic carry;
		top_digit = 0;
		for (int i = COUNT_DIGITS - 1; i > 0; i--)
			if (top_digit == 0 && line_count[i] != 4'd0)
				top_digit = i;
		for (int i = top_digit + 1; i < NUM_FIELD_WIDTH; i++)
			run_bytes.push_back(CH_SPACE);
		for (int i = top_digit; i >= 0; i--)
			run_bytes.push_back(CH_ZERO + {4'd0, line_count[i]});
		run_bytes.push_back(CH_TAB);
		carry = 1'b1;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			if (carry) begin
				if (line_count[i] < 4'd9) begin
					line_count[i] = line_count[i] + 4'd1;
					carry = 1'b0;
				end else begin
					line_count[i] = 4'd0;
				end
			end
		end
	endtask

	// Works out the bytes one input item produces and queues them.
	task automatic annotate_byte(input in_item_t item);
		logic [7:0] c;
		logic       blank;
		out_item_t  r;
		c = item.data_byte;
		run_bytes.delete();
		if (item.new_source)
			line_begin = 1'b1;
		if (c == CH_NL) begin
			blank = line_begin;
			line_begin = 1'b1;
			// A blank line after a blank line vanishes when squeezing.
			if (!(squeeze_blank && blank && prev_blank)) begin
				prev_blank = blank;
				if (blank && number_mode == MODE_ALL)
					emit_line_number();
				if (show_ends)
					run_bytes.push_back(CH_DOLLAR);
				run_bytes.push_back(CH_NL);
			end
		end else begin
			prev_blank = 1'b0;
			if (line_begin && number_mode != MODE_OFF)
				emit_line_number();
			line_begin = 1'b0;
			if (c == CH_TAB) begin
				if (show_tabs) begin
					run_bytes.push_back(CH_CARET);
					run_bytes.push_back(CH_I);
				end else begin
					run_bytes.push_back(CH_TAB);
				end
			end else if (show_nonprinting) begin
				if (c[7]) begin
					run_bytes.push_back(CH_M);
					run_bytes.push_back(CH_DASH);
					c[7] = 1'b0;
				end
				if (c < CH_SPACE) begin
					run_bytes.push_back(CH_CARET);
					run_bytes.push_back(c + CTRL_OFFSET);
				end else if (c[6:0] == CH_DEL7) begin
					run_bytes.push_back(CH_CARET);
					run_bytes.push_back(CH_QMARK);
				end else begin
					run_bytes.push_back(c);
				end
			end else begin
				run_bytes.push_back(c);
			end
		end
		foreach (run_bytes[i]) begin
			r.out_byte = run_bytes[i];
			r.run_last = (i == run_bytes.size() - 1);
			awaited_bytes.push_back(r);
		end
	endtask

	// Results are checked before the input of the same edge is predicted, since no
	// result can come from an item taken on that very edge.
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			number_mode = MODE_OFF;
			show_ends = 1'b0;
			squeeze_blank = 1'b0;
			show_tabs = 1'b0;
			show_nonprinting = 1'b0;
			foreach (line_count[i])
				line_count[i] = 4'd0;
			line_count[0] = 4'd1;
			line_begin = 1'b1;
			prev_blank = 1'b0;
			awaited_bytes.delete();
			failures = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_bytes.size() == 0) begin
					$error("out_byte: expected nothing, actual %h", out_item.out_byte);
					failures++;
				end else begin
					want = awaited_bytes.pop_front();
					if (out_item.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, actual %h", want.out_byte,
							out_item.out_byte);
						failures++;
					end
					if (out_item.run_last !== want.run_last) begin
						$error("run_last: expected %b, actual %b", want.run_last,
							out_item.run_last);
						failures++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_NUMBER_MODE:      number_mode = cfg_data;
					REG_SHOW_ENDS:        show_ends = cfg_data[0];
					REG_SQUEEZE_BLANK:    squeeze_blank = cfg_data[0];
					REG_SHOW_TABS:        show_tabs = cfg_data[0];
					REG_SHOW_NONPRINTING: show_nonprinting = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				annotate_byte(in_item);
		end
		open_count <= awaited_bytes.size();
		fail_count <= failures;
	end

endmodule

// ----- tb/tb_text_line_annotator.sv -----
`timescale 1ns / 100ps
module tb_text_line_annotator;
	import tla_pkg::*;

	localparam int COUNT_DIGITS = 10;
	// Cycles without any handshake before the run is declared hung. The longest
	// legitimate quiet stretch is the receiver's long hold-off.
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	// Enough for the longest item (a number plus an escape) to finish in the block.
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_ITEMS = 250;
	localparam int RANDOM_PHASES = 5;

	localparam logic [1:0] MODE_NONBLANK = 2'd2;
	localparam logic [1:0] MODE_BOTH     = 2'd3;
	localparam logic [2:0] REG_INDEX_LAST = 3'd7;
	localparam logic [7:0] CH_DEL = {1'b0, CH_DEL7};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_item = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_item;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_NUMBER_MODE;
	logic [1:0] cfg_data = '0;

	int   fail_count;
	int   open_count;
	int   idle_cycles = 0;
	int   random_sent = 0;
	// Set by the stimulus to let the sender leave gaps between items.
	logic gaps_on = 1'b1;
	// A request to the receiver for one long hold-off; the receiver clears it.
	logic hold_request = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	text_line_annotator #(.COUNT_DIGITS(COUNT_DIGITS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tla_annotation_check #(.COUNT_DIGITS(COUNT_DIGITS)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	// Offers one item and holds it until it is taken, then perhaps leaves a gap.
	// The valid line is only lowered when a gap follows, so back-to-back items
	// never see it dropped and raised within one step.
	task automatic send_byte(input logic [7:0] data, input logic fresh);
		in_item_t item;
		int       gap;
		int       r;
		item.data_byte = data;
		item.new_source = fresh;
		in_valid <= 1'b1;
		in_item <= item;
		do @(posedge clk); while (in_stall);
		gap = 0;
		if (gaps_on) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(8, 40);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Writes every register on consecutive edges. The one-bit registers get a
	// random upper data bit, which the block has to mask off, and a final write
	// goes to an index that holds no register at all.
	task automatic configure(input logic [1:0] mode, input logic ends, input logic squeeze,
			input logic tabs, input logic nonprinting);
		write_reg(REG_NUMBER_MODE, mode);
		write_reg(REG_SHOW_ENDS, {1'($urandom_range(0, 1)), ends});
		write_reg(REG_SQUEEZE_BLANK, {1'($urandom_range(0, 1)), squeeze});
		write_reg(REG_SHOW_TABS, {1'($urandom_range(0, 1)), tabs});
		write_reg(REG_SHOW_NONPRINTING, {1'($urandom_range(0, 1)), nonprinting});
		write_reg(3'($urandom_range(REG_SHOW_NONPRINTING + 1, REG_INDEX_LAST)),
			2'($urandom_range(0, 3)));
		cfg_we <= 1'b0;
	endtask

	// Waits for every predicted byte to come out, then lets the block settle, as a
	// squeezed newline may still be in work with nothing left to show for it.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly printable text, with a fair share of tabs, control bytes, deletes
	// and arbitrary bytes (stray newlines and high bytes among them) as noise.
	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 8'($urandom_range(32, 126));
		else if (r < 65)
			return CH_TAB;
		else if (r < 75)
			return 8'($urandom_range(0, 31));
		else if (r < 80)
			return CH_DEL;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic fresh_source();
		return $urandom_range(0, 19) == 0;
	endfunction

	// One line: blank fairly often so that squeezing has work to do, now and then
	// a long one.
	task automatic send_random_line();
		int len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			len = 0;
		else if (r < 90)
			len = $urandom_range(1, 6);
		else
			len = $urandom_range(10, 20);
		repeat (len) send_byte(text_char(), fresh_source());
		send_byte(CH_NL, fresh_source());
		random_sent += len + 1;
	endtask

	// Receiver: stalls of random length, mostly short and a few long, with now and
	// then a long stretch of free flow. On request it holds off for a long time so
	// that the block fills up and stalls the sender.
	initial begin : receiver
		int hold;
		int run;
		int r;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50)
					hold = 0;
				else if (r < 92)
					hold = $urandom_range(1, 3);
				else
					hold = $urandom_range(10, 40);
				if ($urandom_range(0, 9) == 0)
					run = $urandom_range(30, 80);
				else
					run = $urandom_range(1, 6);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	// Watchdog: any handshake on any port counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Everything on, numbering every line. Covers the extremes of the byte,
		// every escape form, a high byte with a control byte under it, blank lines
		// that are numbered and then squeezed away, and a new source arriving in
		// the middle of a line and on an empty line.
		configure(MODE_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
		send_byte("A", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(CH_DEL, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(8'h89, 1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte("y", 1'b0);
		send_byte("z", 1'b1);
		send_byte(CH_NL, 1'b1);
		drain();

		// Numbering of nonblank lines only, every other option off: bytes pass
		// through unchanged, blank lines go unnumbered.
		configure(MODE_NONBLANK, 1'b0, 1'b0, 1'b0, 1'b0);
		send_byte("a", 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(8'hC1, 1'b1);
		send_byte(CH_TAB, 1'b0);
		send_byte("b", 1'b1);
		send_byte(CH_NL, 1'b0);
		drain();

		// Random text under a series of settings. The first phase carries the
		// receiver's long hold-off, the third runs the sender without gaps.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: configure(MODE_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
				1: configure(MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
				2: configure(MODE_BOTH, 1'($urandom_range(0, 1)), 1'b1,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				default: configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			endcase
			gaps_on = (p != 2);
			if (p == 0)
				hold_request = 1'b1;
			while (random_sent < (p + 1) * RANDOM_ITEMS / RANDOM_PHASES)
				send_random_line();
			drain();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
